// ===== rtl/pcs_pkg.sv =====
// Shared types and constants for the packet class statistics counter.
package pcs_pkg;

   localparam logic [15:0] L2_PROTO_IPV4 = 16'h0800;
   localparam logic [15:0] L2_PROTO_IPV6 = 16'h86DD;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;
   localparam logic [7:0]  PROTO_UDP     = 8'd17;
   localparam logic [7:0]  PROTO_ICMP    = 8'd1;
   localparam logic [7:0]  PROTO_ICMPV6  = 8'd58;
   localparam int unsigned BUCKET_BYTES  = 100;

   localparam logic [1:0] KIND_IPV4  = 2'd0;
   localparam logic [1:0] KIND_IPV6  = 2'd1;
   localparam logic [1:0] KIND_NONIP = 2'd2;

   localparam logic [2:0] CLS_TCP    = 3'd0;
   localparam logic [2:0] CLS_UDP    = 3'd1;
   localparam logic [2:0] CLS_ICMP   = 3'd2;
   localparam logic [2:0] CLS_ICMPV6 = 3'd3;
   localparam logic [2:0] CLS_OTHER  = 3'd4;

   localparam logic [1:0] TALK_HIT    = 2'd0;
   localparam logic [1:0] TALK_INSERT = 2'd1;
   localparam logic [1:0] TALK_FULL   = 2'd2;
   localparam logic [1:0] TALK_NONIP  = 2'd3;

   localparam logic [0:0] REQ_PACKET = 1'b0;
   localparam logic [0:0] REQ_READ   = 1'b1;

   localparam logic [5:0] RD_PACKETS = 6'd0;
   localparam logic [5:0] RD_TCP     = 6'd1;
   localparam logic [5:0] RD_UDP     = 6'd2;
   localparam logic [5:0] RD_ICMP    = 6'd3;
   localparam logic [5:0] RD_ICMPV6  = 6'd4;
   localparam logic [5:0] RD_IPV4    = 6'd5;
   localparam logic [5:0] RD_IPV6    = 6'd6;
   localparam logic [5:0] RD_OTHER   = 6'd7;
   localparam logic [5:0] RD_BYTES   = 6'd8;
   localparam int unsigned RD_HIST_BASE = 9;

   typedef struct packed {
      logic [0:0]  req_type;
      logic [15:0] pkt_len;
      logic [15:0] l2_proto;
      logic [7:0]  ip_proto;
      logic [63:0] src_addr_hi;
      logic [63:0] src_addr_lo;
      logic [5:0]  read_index;
   } req_type_type;

   typedef struct packed {
      logic [1:0]  l3_kind;
      logic [2:0]  pkt_class;
      logic [3:0]  size_bucket;
      logic [3:0]  talker_slot;
      logic [1:0]  talker_status;
      logic [63:0] read_data;
   } rsp_type;

   // Classified work handed from the front end to the counter engine.
   typedef struct packed {
      logic        is_read;
      logic [5:0]  read_index;
      logic [15:0] pkt_len;
      logic [1:0]  l3_kind;
      logic [2:0]  pkt_class;
      logic [3:0]  size_bucket;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
   } work_type;

endpackage

// ===== rtl/packet_class_stats_counter_unit.sv =====
// Top level of the packet class statistics counter.
// One request per cycle is accepted, packet or read, while the queue has room;
// each gives one response. The front end classifies in the accept cycle, a
// two-entry queue follows, and the counter engine updates all statistics and
// the talker table (a parallel compare over every entry) and registers the
// response. Reads see every earlier packet.
module packet_class_stats_counter_unit import pcs_pkg::*; #(
   parameter int SIZE_BUCKETS   = 10,
   parameter int TALKER_ENTRIES = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   logic     f_valid, f_ready, e_valid, e_ready;
   work_type f_data, e_data;

   pcs_front #(.SIZE_BUCKETS(SIZE_BUCKETS)) u_front (
      .req_valid, .req_ready, .req_data,
      .wk_valid(f_valid), .wk_ready(f_ready), .wk_data(f_data));

   pcs_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(e_valid), .out_ready(e_ready), .out_data(e_data));

   pcs_engine #(.SIZE_BUCKETS(SIZE_BUCKETS), .TALKER_ENTRIES(TALKER_ENTRIES)) u_engine (
      .clock, .reset, .wk_valid(e_valid), .wk_ready(e_ready), .wk_data(e_data),
      .rsp_valid, .rsp_ready, .rsp_data);

endmodule

// ===== rtl/pcs_front.sv =====
// Front end: accepts requests and classifies packets.
module pcs_front import pcs_pkg::*; #(
   parameter int SIZE_BUCKETS = 10
) (
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type_type req_data,
   output logic         wk_valid,
   input  logic         wk_ready,
   output work_type     wk_data
);

   work_type cls;
   logic [15:0] quot;
   logic [31:0] prod;

   assign req_ready = wk_ready;
   assign wk_valid  = req_valid;
   assign wk_data   = cls;

   always_comb begin
      // len / 100 by reciprocal: floor(len * 5243 / 2^19) is exact below 43690,
      // and any larger length lands in the last bucket regardless.
      prod = 32'(req_data.pkt_len) * 32'd5243;
      quot = 16'(prod >> 19);
      cls = '0;
      cls.is_read    = (req_data.req_type == REQ_READ);
      cls.read_index = req_data.read_index;
      cls.pkt_len    = req_data.pkt_len;
      cls.size_bucket = (quot >= 16'(SIZE_BUCKETS)) ? 4'(SIZE_BUCKETS - 1) : quot[3:0];
      if (req_data.l2_proto == L2_PROTO_IPV4) begin
         cls.l3_kind = KIND_IPV4;
         cls.addr_lo = {32'd0, req_data.src_addr_lo[31:0]};
         case (req_data.ip_proto)
            PROTO_TCP:  cls.pkt_class = CLS_TCP;
            PROTO_UDP:  cls.pkt_class = CLS_UDP;
            PROTO_ICMP: cls.pkt_class = CLS_ICMP;
            default:    cls.pkt_class = CLS_OTHER;
         endcase
      end else if (req_data.l2_proto == L2_PROTO_IPV6) begin
         cls.l3_kind = KIND_IPV6;
         cls.addr_hi = req_data.src_addr_hi;
         cls.addr_lo = req_data.src_addr_lo;
         case (req_data.ip_proto)
            PROTO_TCP:    cls.pkt_class = CLS_TCP;
            PROTO_UDP:    cls.pkt_class = CLS_UDP;
            PROTO_ICMPV6: cls.pkt_class = CLS_ICMPV6;
            default:      cls.pkt_class = CLS_OTHER;
         endcase
      end else begin
         cls.l3_kind   = KIND_NONIP;
         cls.pkt_class = CLS_OTHER;
      end
   end

endmodule

// ===== rtl/pcs_queue.sv =====
// Two-entry queue that decouples the front end from the counter engine.
module pcs_queue import pcs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  work_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output work_type out_data
);

   work_type    slot_ff [2];
   logic        rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      rd_ptr_in = rd_ptr_ff ^ pop;
      wr_ptr_in = wr_ptr_ff ^ push;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
      if (push) slot_ff[wr_ptr_ff] <= in_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !in_ready) else $error("queue overflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1) else $error("count step");
   a_count_range: assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("count range");

endmodule

// ===== rtl/pcs_engine.sv =====
// Counter engine: updates statistics, the talker table and serves reads.
module pcs_engine import pcs_pkg::*; #(
   parameter int SIZE_BUCKETS   = 10,
   parameter int TALKER_ENTRIES = 10
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wk_valid,
   output logic     wk_ready,
   input  work_type wk_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int TB = RD_HIST_BASE + SIZE_BUCKETS;
   localparam int AH = TB + TALKER_ENTRIES;
   localparam int AL = AH + TALKER_ENTRIES;
   localparam int FL = AL + TALKER_ENTRIES;

   logic [31:0] cnt_ff [8];
   logic [63:0] bytes_ff;
   logic [31:0] hist_ff [SIZE_BUCKETS];
   logic [31:0] tcnt_ff [TALKER_ENTRIES];
   logic [63:0] thi_ff  [TALKER_ENTRIES];
   logic [63:0] tlo_ff  [TALKER_ENTRIES];
   logic [TALKER_ENTRIES-1:0] tv6_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   logic        go, pkt;
   logic        v6, hit_any, free_any;
   logic [3:0]  hit_idx, free_idx;
   logic [64:0] bsum;
   logic [63:0] rd_word;
   int unsigned ri;

   assign wk_ready  = !rsp_valid_ff || rsp_ready;
   assign go        = wk_valid && wk_ready;
   assign pkt       = go && !wk_data.is_read;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign v6        = (wk_data.l3_kind == KIND_IPV6);
   assign bsum      = {1'b0, bytes_ff} + 65'(wk_data.pkt_len);

   // Parallel match and first-free search over the talker table.
   always_comb begin
      hit_any = 1'b0; free_any = 1'b0; hit_idx = '0; free_idx = '0;
      for (int i = 0; i < TALKER_ENTRIES; i++) begin
         if (tcnt_ff[i] == 32'd0) begin
            if (!free_any) begin free_any = 1'b1; free_idx = 4'(i); end
         end else if (!hit_any && thi_ff[i] == wk_data.addr_hi &&
                      tlo_ff[i] == wk_data.addr_lo && tv6_ff[i] == v6) begin
            hit_any = 1'b1; hit_idx = 4'(i);
         end
      end
   end

   always_comb begin
      ri = 32'(wk_data.read_index);
      rd_word = '0;
      if (ri <= 32'(RD_OTHER)) rd_word = {32'd0, cnt_ff[ri[2:0]]};
      else if (ri == 32'(RD_BYTES)) rd_word = bytes_ff;
      else if (ri < TB) begin
         for (int i = 0; i < SIZE_BUCKETS; i++)
            if (ri == RD_HIST_BASE + i) rd_word = {32'd0, hist_ff[i]};
      end else if (ri < AH) begin
         for (int i = 0; i < TALKER_ENTRIES; i++)
            if (ri == TB + i) rd_word = {32'd0, tcnt_ff[i]};
      end else if (ri < AL) begin
         for (int i = 0; i < TALKER_ENTRIES; i++)
            if (ri == AH + i) rd_word = thi_ff[i];
      end else if (ri < FL) begin
         for (int i = 0; i < TALKER_ENTRIES; i++)
            if (ri == AL + i) rd_word = tlo_ff[i];
      end else if (ri == FL) rd_word = 64'(tv6_ff);
   end

   always_comb begin
      rsp_in = '0;
      if (wk_data.is_read) rsp_in.read_data = rd_word;
      else begin
         rsp_in.l3_kind     = wk_data.l3_kind;
         rsp_in.pkt_class   = wk_data.pkt_class;
         rsp_in.size_bucket = wk_data.size_bucket;
         if (wk_data.l3_kind == KIND_NONIP) rsp_in.talker_status = TALK_NONIP;
         else if (hit_any) begin
            rsp_in.talker_status = TALK_HIT; rsp_in.talker_slot = hit_idx;
         end else if (free_any) begin
            rsp_in.talker_status = TALK_INSERT; rsp_in.talker_slot = free_idx;
         end else rsp_in.talker_status = TALK_FULL;
      end
   end

   function automatic logic [31:0] sat_inc(input logic [31:0] c);
      return (c == '1) ? c : c + 32'd1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) cnt_ff[i] <= '0;
         bytes_ff <= '0;
         for (int i = 0; i < SIZE_BUCKETS; i++) hist_ff[i] <= '0;
         for (int i = 0; i < TALKER_ENTRIES; i++) begin
            tcnt_ff[i] <= '0; thi_ff[i] <= '0; tlo_ff[i] <= '0;
         end
         tv6_ff <= '0;
      end else begin
         if (go) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (pkt) begin
            cnt_ff[RD_PACKETS[2:0]] <= sat_inc(cnt_ff[RD_PACKETS[2:0]]);
            bytes_ff <= bsum[64] ? '1 : bsum[63:0];
            case (wk_data.l3_kind)
               KIND_IPV4: cnt_ff[RD_IPV4[2:0]] <= sat_inc(cnt_ff[RD_IPV4[2:0]]);
               KIND_IPV6: cnt_ff[RD_IPV6[2:0]] <= sat_inc(cnt_ff[RD_IPV6[2:0]]);
               default: ;
            endcase
            case (wk_data.pkt_class)
               CLS_TCP:    cnt_ff[RD_TCP[2:0]]    <= sat_inc(cnt_ff[RD_TCP[2:0]]);
               CLS_UDP:    cnt_ff[RD_UDP[2:0]]    <= sat_inc(cnt_ff[RD_UDP[2:0]]);
               CLS_ICMP:   cnt_ff[RD_ICMP[2:0]]   <= sat_inc(cnt_ff[RD_ICMP[2:0]]);
               CLS_ICMPV6: cnt_ff[RD_ICMPV6[2:0]] <= sat_inc(cnt_ff[RD_ICMPV6[2:0]]);
               default:    cnt_ff[RD_OTHER[2:0]]  <= sat_inc(cnt_ff[RD_OTHER[2:0]]);
            endcase
            for (int i = 0; i < SIZE_BUCKETS; i++)
               if (wk_data.size_bucket == 4'(i)) hist_ff[i] <= sat_inc(hist_ff[i]);
            if (wk_data.l3_kind != KIND_NONIP) begin
               for (int i = 0; i < TALKER_ENTRIES; i++) begin
                  if (hit_any && hit_idx == 4'(i)) tcnt_ff[i] <= sat_inc(tcnt_ff[i]);
                  else if (!hit_any && free_any && free_idx == 4'(i)) begin
                     tcnt_ff[i] <= 32'd1;
                     thi_ff[i]  <= wk_data.addr_hi;
                     tlo_ff[i]  <= wk_data.addr_lo;
                     tv6_ff[i]  <= v6;
                  end
               end
            end
         end
      end
      if (go) rsp_ff <= rsp_in;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_ff)) else $error("rsp hold");
   a_read_quiet: assert property (@(posedge clock) disable iff (reset)
      go && wk_data.is_read |=> $stable(bytes_ff) && $stable(tv6_ff)) else $error("read changed state");
   a_hit_free: assert property (@(posedge clock) disable iff (reset)
      hit_any |-> tcnt_ff[hit_idx] != 32'd0) else $error("hit on free entry");
   a_total: assert property (@(posedge clock) disable iff (reset)
      pkt |=> cnt_ff[0] != 32'd0) else $error("total not counted");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the packet class statistics counter.
`timescale 1ns / 1ps

module tb;
   import pcs_pkg::*;

   localparam int NBUCKETS = 10;
   localparam int NTALKERS = 10;
   localparam int RD_TALK_COUNT = RD_HIST_BASE + NBUCKETS;
   localparam int RD_TALK_HI = RD_TALK_COUNT + NTALKERS;
   localparam int RD_TALK_LO = RD_TALK_HI + NTALKERS;
   localparam int RD_TALK_V6 = RD_TALK_LO + NTALKERS;
   localparam int STALL_LIMIT = 2000;
   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int packets_sent = 0;
   int reads_sent = 0;
   int idle_cycles = 0;
   bit timed_out = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   packet_class_stats_counter_unit #(
      .SIZE_BUCKETS(NBUCKETS),
      .TALKER_ENTRIES(NTALKERS)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   class stats_scoreboard;
      logic [31:0] packet_total, tcp_cnt, udp_cnt, icmp_cnt, icmpv6_cnt;
      logic [31:0] ipv4_cnt, ipv6_cnt, other_cnt;
      logic [63:0] byte_total;
      logic [31:0] histogram[NBUCKETS];
      logic [31:0] talk_count[NTALKERS];
      logic [63:0] talk_hi[NTALKERS];
      logic [63:0] talk_lo[NTALKERS];
      logic talk_v6[NTALKERS];
      rsp_type expected_rsps[$];

      function new();
         packet_total = 0; tcp_cnt = 0; udp_cnt = 0; icmp_cnt = 0; icmpv6_cnt = 0;
         ipv4_cnt = 0; ipv6_cnt = 0; other_cnt = 0; byte_total = 0;
         for (int i = 0; i < NBUCKETS; i++) histogram[i] = 0;
         for (int i = 0; i < NTALKERS; i++) begin
            talk_count[i] = 0; talk_hi[i] = 0; talk_lo[i] = 0; talk_v6[i] = 0;
         end
      endfunction

      function automatic logic [31:0] bump(input logic [31:0] c);
         return (c == MAX32) ? c : c + 32'd1;
      endfunction

      function automatic logic [63:0] stat_word(input int idx);
         logic [63:0] flags;
         flags = 0;
         case (idx)
            RD_PACKETS: return {32'd0, packet_total};
            RD_TCP:     return {32'd0, tcp_cnt};
            RD_UDP:     return {32'd0, udp_cnt};
            RD_ICMP:    return {32'd0, icmp_cnt};
            RD_ICMPV6:  return {32'd0, icmpv6_cnt};
            RD_IPV4:    return {32'd0, ipv4_cnt};
            RD_IPV6:    return {32'd0, ipv6_cnt};
            RD_OTHER:   return {32'd0, other_cnt};
            RD_BYTES:   return byte_total;
            default: ;
         endcase
         if (idx < RD_TALK_COUNT) return {32'd0, histogram[idx - RD_HIST_BASE]};
         if (idx < RD_TALK_HI) return {32'd0, talk_count[idx - RD_TALK_COUNT]};
         if (idx < RD_TALK_LO) return talk_hi[idx - RD_TALK_HI];
         if (idx < RD_TALK_V6) return talk_lo[idx - RD_TALK_LO];
         if (idx == RD_TALK_V6) begin
            for (int i = 0; i < NTALKERS; i++) flags[i] = talk_v6[i];
            return flags;
         end
         return 0;
      endfunction

      function void note_request(input req_type_type r);
         rsp_type e;
         logic v6;
         logic [63:0] hi, lo;
         int hit, free_slot, b;
         e = '0;
         hit = -1;
         free_slot = -1;
         if (r.req_type == REQ_READ) begin
            e.read_data = stat_word(int'(r.read_index));
            expected_rsps.push_back(e);
            return;
         end
         packet_total = bump(packet_total);
         if (byte_total > 64'hFFFF_FFFF_FFFF_FFFF - 64'(r.pkt_len))
            byte_total = 64'hFFFF_FFFF_FFFF_FFFF;
         else
            byte_total = byte_total + 64'(r.pkt_len);
         e.pkt_class = CLS_OTHER;
         if (r.l2_proto == L2_PROTO_IPV4) begin
            e.l3_kind = KIND_IPV4;
            ipv4_cnt = bump(ipv4_cnt);
         end else if (r.l2_proto == L2_PROTO_IPV6) begin
            e.l3_kind = KIND_IPV6;
            ipv6_cnt = bump(ipv6_cnt);
         end else begin
            e.l3_kind = KIND_NONIP;
         end
         if (e.l3_kind != KIND_NONIP) begin
            if (r.ip_proto == PROTO_TCP) begin
               e.pkt_class = CLS_TCP; tcp_cnt = bump(tcp_cnt);
            end else if (r.ip_proto == PROTO_UDP) begin
               e.pkt_class = CLS_UDP; udp_cnt = bump(udp_cnt);
            end else if (r.ip_proto == PROTO_ICMP && e.l3_kind == KIND_IPV4) begin
               e.pkt_class = CLS_ICMP; icmp_cnt = bump(icmp_cnt);
            end else if (r.ip_proto == PROTO_ICMPV6 && e.l3_kind == KIND_IPV6) begin
               e.pkt_class = CLS_ICMPV6; icmpv6_cnt = bump(icmpv6_cnt);
            end
         end
         if (e.pkt_class == CLS_OTHER) other_cnt = bump(other_cnt);
         b = int'(r.pkt_len) / int'(BUCKET_BYTES);
         if (b >= NBUCKETS) b = NBUCKETS - 1;
         histogram[b] = bump(histogram[b]);
         e.size_bucket = 4'(b);
         if (e.l3_kind == KIND_NONIP) begin
            e.talker_status = TALK_NONIP;
         end else begin
            v6 = (e.l3_kind == KIND_IPV6);
            hi = v6 ? r.src_addr_hi : 64'd0;
            lo = v6 ? r.src_addr_lo : {32'd0, r.src_addr_lo[31:0]};
            for (int i = 0; i < NTALKERS; i++) begin
               if (talk_count[i] == 0) begin
                  if (free_slot < 0) free_slot = i;
               end else if (hit < 0 && talk_hi[i] == hi && talk_lo[i] == lo &&
                            talk_v6[i] == v6) begin
                  hit = i;
               end
            end
            if (hit >= 0) begin
               talk_count[hit] = bump(talk_count[hit]);
               e.talker_slot = 4'(hit);
               e.talker_status = TALK_HIT;
            end else if (free_slot >= 0) begin
               talk_count[free_slot] = 32'd1;
               talk_hi[free_slot] = hi;
               talk_lo[free_slot] = lo;
               talk_v6[free_slot] = v6;
               e.talker_slot = 4'(free_slot);
               e.talker_status = TALK_INSERT;
            end else begin
               e.talker_status = TALK_FULL;
            end
         end
         expected_rsps.push_back(e);
      endfunction

      task check_response(input rsp_type got);
         rsp_type want;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", got.read_data, 64'd0);
            return;
         end
         want = expected_rsps.pop_front();
         if (got.l3_kind !== want.l3_kind)
            report_mismatch("l3_kind", 64'(got.l3_kind), 64'(want.l3_kind));
         if (got.pkt_class !== want.pkt_class)
            report_mismatch("pkt_class", 64'(got.pkt_class), 64'(want.pkt_class));
         if (got.size_bucket !== want.size_bucket)
            report_mismatch("size_bucket", 64'(got.size_bucket), 64'(want.size_bucket));
         if (got.talker_slot !== want.talker_slot)
            report_mismatch("talker_slot", 64'(got.talker_slot), 64'(want.talker_slot));
         if (got.talker_status !== want.talker_status)
            report_mismatch("talker_status", 64'(got.talker_status),
                            64'(want.talker_status));
         if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
      endtask
   endclass

   stats_scoreboard stats = new();

   // Sample both handshakes at the rising edge; the watchdog counts quiet cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) stats.note_request(req_data);
         if (rsp_valid && rsp_ready) stats.check_response(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("simulation failed");
         $finish;
      end
   end

   // The receiver stalls at random; it decides anew at every falling edge.
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Valid stays high between back-to-back requests and drops only while idling.
   task automatic send_request(input req_type_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_packet(input logic [15:0] len, input logic [15:0] et,
                              input logic [7:0] proto, input logic [63:0] hi,
                              input logic [63:0] lo);
      req_type_type r;
      r = '0;
      r.req_type = REQ_PACKET;
      r.pkt_len = len;
      r.l2_proto = et;
      r.ip_proto = proto;
      r.src_addr_hi = hi;
      r.src_addr_lo = lo;
      r.read_index = 6'($urandom);
      send_request(r);
      packets_sent++;
   endtask

   task automatic send_read(input logic [5:0] idx);
      req_type_type r;
      r = '0;
      r.pkt_len = 16'($urandom);
      r.l2_proto = 16'($urandom);
      r.ip_proto = 8'($urandom);
      r.src_addr_hi = {$urandom, $urandom};
      r.src_addr_lo = {$urandom, $urandom};
      r.req_type = REQ_READ;
      r.read_index = idx;
      send_request(r);
      reads_sent++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Mostly IP traffic from a small address pool, though the directed phase has
   // already filled the talker table; the rest is arbitrary noise and statistics reads.
   task automatic random_traffic(input int count);
      logic [63:0] pool_hi[6], pool_lo[6];
      logic [15:0] et, len;
      logic [7:0] proto;
      int p;
      for (int i = 0; i < 6; i++) begin
         pool_hi[i] = rand64(); pool_lo[i] = rand64();
      end
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 20) begin
            send_read(6'($urandom_range(63)));
         end else begin
            case ($urandom_range(9))
               0: et = 16'($urandom);
               1, 2, 3, 4: et = L2_PROTO_IPV4;
               default: et = L2_PROTO_IPV6;
            endcase
            case ($urandom_range(6))
               0: proto = PROTO_TCP;
               1: proto = PROTO_UDP;
               2: proto = PROTO_ICMP;
               3: proto = PROTO_ICMPV6;
               default: proto = 8'($urandom);
            endcase
            len = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1100));
            p = int'($urandom_range(5));
            if ($urandom_range(9) == 0)
               send_packet(len, et, proto, rand64(), rand64());
            else
               send_packet(len, et, proto, pool_hi[p], pool_lo[p]);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (stats.expected_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: every class, both family mismatches, length extremes,
      // non-IP, IPv4 upper bits ignored, then table full and all reads.
      send_packet(16'd0, L2_PROTO_IPV4, PROTO_TCP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
      send_packet(16'hFFFF, L2_PROTO_IPV4, PROTO_UDP, 64'h0, 64'hFFFF_FFFF_0000_0000);
      send_packet(16'd99, L2_PROTO_IPV4, PROTO_ICMP, 64'h0, 64'h1234_0000_0000_0000);
      send_packet(16'd100, L2_PROTO_IPV4, PROTO_ICMPV6, 64'h5, 64'h0);
      send_packet(16'd999, L2_PROTO_IPV6, PROTO_ICMPV6, 64'h0, 64'h0);
      send_packet(16'd1000, L2_PROTO_IPV6, PROTO_ICMP, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF);
      send_packet(16'd1500, L2_PROTO_IPV6, PROTO_TCP, 64'h0, 64'h0);
      send_packet(16'd64, 16'hFFFF, PROTO_TCP, 64'h1, 64'h1);
      send_packet(16'd64, 16'h0000, 8'hFF, 64'h1, 64'h1);
      for (int i = 0; i < 10; i++)
         send_packet(16'd200, L2_PROTO_IPV6, 8'hFF, 64'hA0 + 64'(i), 64'hB0 + 64'(i));
      for (int i = 0; i < 64; i++) send_read(6'(i));
      drain();

      recv_stall_pct = 0; send_idle_pct = 0; random_traffic(400);
      send_idle_pct = 48; random_traffic(350);
      send_idle_pct = 0; recv_stall_pct = 48; random_traffic(350);
      send_idle_pct = 10; recv_stall_pct = 10; random_traffic(350);
      for (int i = 0; i < 64; i++) send_read(6'(i));
      drain();
      repeat (4) @(posedge clock);

      $display("Sent %0d packet requests and %0d statistics reads under four idle mixes.",
               packets_sent, reads_sent);
      if (mismatch_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
